FILE: rtl/core/acss_pkg.sv
package acss_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CODE_DEPTH = 4;

  localparam logic [1:0] CH_LAST = 2'(NUM_CHANNELS - 1);

  localparam logic [15:0] POLL_RESET = 16'd1000;
  localparam logic [7:0] SETTLE_RESET = 8'd20;

  localparam logic [7:0] CFG_HI_BASE = 8'hC5;
  localparam logic [7:0] CFG_LO = 8'h83;

  localparam logic REG_POLL = 1'b0;
  localparam logic REG_SETTLE = 1'b1;

  typedef enum logic [2:0] {
    PH_DETECT = 3'd0,
    PH_START = 3'd1,
    PH_READ = 3'd2,
    PH_ERROR = 3'd3,
    PH_WAIT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_DETECT = 2'd1,
    BUS_WRITE_CFG = 2'd2,
    BUS_PTR_READ = 2'd3
  } bus_action_t;

  typedef struct packed {
    logic [15:0] poll_interval;
    logic [7:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] bus_action;
    logic [15:0] config_word;
    logic [1:0] active_channel;
    logic sample_stored;
    logic error_flag;
    logic ready_flag;
    logic [15:0] query_code;
  } result_t;

  function automatic logic [15:0] single_shot_word(input logic [1:0] ch);
    logic [7:0] hi;
    hi = CFG_HI_BASE | {2'b00, ch, 4'b0000};
    return {hi, CFG_LO};
  endfunction

endpackage

FILE: rtl/core/acss_cfg.sv
module acss_cfg (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output acss_pkg::cfg_t cfg
);
  import acss_pkg::*;

  logic [15:0] poll_interval;
  logic [7:0] settle_ticks;
  logic wr;
  logic reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_interval <= POLL_RESET;
      settle_ticks <= SETTLE_RESET;
    end else if (wr) begin
      unique case (reg_sel)
        REG_POLL: poll_interval <= pwdata[15:0];
        REG_SETTLE: settle_ticks <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POLL: prdata = {16'd0, poll_interval};
      REG_SETTLE: prdata = {24'd0, settle_ticks};
    endcase
  end

  assign cfg.poll_interval = poll_interval;
  assign cfg.settle_ticks = settle_ticks;

endmodule

FILE: rtl/core/acss_step.sv
module acss_step (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  acss_pkg::cfg_t cfg,
  input  logic [31:0] now_tick,
  input  logic first_ok,
  input  logic second_ok,
  input  logic [15:0] read_word,
  input  logic [1:0] query_channel,
  output acss_pkg::result_t result
);
  import acss_pkg::*;

  phase_t phase, phase_next;
  logic [1:0] scan_channel, scan_channel_next;
  logic [31:0] time_stamp, time_stamp_next;
  logic fault, fault_next;
  logic scan_done, scan_done_next;
  logic [15:0] channel_codes [CODE_DEPTH];
  logic [15:0] channel_codes_next [CODE_DEPTH];

  logic [31:0] age;
  logic settled;
  logic poll_over;
  bus_action_t action;
  logic [15:0] cfg_word;
  logic stored;

  assign age = now_tick - time_stamp;
  assign settled = age >= {24'd0, cfg.settle_ticks};
  assign poll_over = age >= {16'd0, cfg.poll_interval};

  always_comb begin
    phase_next = phase;
    scan_channel_next = scan_channel;
    time_stamp_next = time_stamp;
    fault_next = fault;
    scan_done_next = scan_done;
    channel_codes_next = channel_codes;
    action = BUS_NONE;
    cfg_word = 16'd0;
    stored = 1'b0;
    unique case (phase)
      PH_START: begin
        action = BUS_WRITE_CFG;
        cfg_word = single_shot_word(scan_channel);
        if (first_ok) begin
          time_stamp_next = now_tick;
          phase_next = PH_READ;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_READ: begin
        if (settled) begin
          action = BUS_PTR_READ;
          if (first_ok && second_ok) begin
            channel_codes_next[scan_channel] = read_word;
            stored = 1'b1;
            if (scan_channel != CH_LAST) begin
              scan_channel_next = scan_channel + 2'd1;
              phase_next = PH_START;
            end else begin
              scan_done_next = 1'b1;
              phase_next = PH_WAIT;
            end
          end else begin
            phase_next = PH_ERROR;
          end
        end
      end
      PH_ERROR: begin
        fault_next = 1'b1;
        scan_done_next = 1'b0;
        for (int i = 0; i < CODE_DEPTH; i++) begin
          channel_codes_next[i] = 16'd0;
        end
        time_stamp_next = now_tick;
        phase_next = PH_WAIT;
      end
      PH_WAIT: begin
        if (poll_over) begin
          phase_next = PH_DETECT;
        end
      end
      default: begin
        action = BUS_DETECT;
        if (first_ok) begin
          fault_next = 1'b0;
          scan_channel_next = 2'd0;
          phase_next = PH_START;
        end else begin
          phase_next = PH_ERROR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DETECT;
      scan_channel <= 2'd0;
      time_stamp <= 32'd0;
      fault <= 1'b0;
      scan_done <= 1'b0;
      for (int i = 0; i < CODE_DEPTH; i++) begin
        channel_codes[i] <= 16'd0;
      end
    end else if (fire) begin
      phase <= phase_next;
      scan_channel <= scan_channel_next;
      time_stamp <= time_stamp_next;
      fault <= fault_next;
      scan_done <= scan_done_next;
      channel_codes <= channel_codes_next;
    end
  end

  assign result.bus_action = action;
  assign result.config_word = cfg_word;
  assign result.active_channel = scan_channel;
  assign result.sample_stored = stored;
  assign result.error_flag = fault_next;
  assign result.ready_flag = scan_done_next;
  assign result.query_code = channel_codes_next[query_channel];

endmodule

FILE: rtl/core/adc_channel_scan_sequencer.sv
// Flow: a step accepted into the input register is worked out and registered
//   in the result register once the output is free; result_valid then rises.
// Throughput: one step per cycle; the input register feeds the result
//   register directly, so steps flow back to back unless result_ready stalls.
// Reset: synchronous rst returns to detect with codes, flags, stamp and
//   channel cleared, and poll_interval 1000, settle_ticks 20.
module adc_channel_scan_sequencer (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic item_valid,
  output logic item_ready,
  input  logic [31:0] now_tick,
  input  logic first_ok,
  input  logic second_ok,
  input  logic [15:0] read_word,
  input  logic [1:0] query_channel,
  output logic result_valid,
  input  logic result_ready,
  output logic [1:0] bus_action,
  output logic [15:0] config_word,
  output logic [1:0] active_channel,
  output logic sample_stored,
  output logic error_flag,
  output logic ready_flag,
  output logic [15:0] query_code
);
  import acss_pkg::*;

  cfg_t cfg;
  result_t step_result;
  result_t res;

  logic held;
  logic [31:0] now_q;
  logic first_ok_q;
  logic second_ok_q;
  logic [15:0] read_word_q;
  logic [1:0] query_q;
  logic advance;

  acss_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  acss_step u_step (
    .clk(clk),
    .rst(rst),
    .fire(advance),
    .cfg(cfg),
    .now_tick(now_q),
    .first_ok(first_ok_q),
    .second_ok(second_ok_q),
    .read_word(read_word_q),
    .query_channel(query_q),
    .result(step_result)
  );

  assign advance = held && (!result_valid || result_ready);
  assign item_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_ready) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      now_q <= now_tick;
      first_ok_q <= first_ok;
      second_ok_q <= second_ok;
      read_word_q <= read_word;
      query_q <= query_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_result;
    end
  end

  assign bus_action = res.bus_action;
  assign config_word = res.config_word;
  assign active_channel = res.active_channel;
  assign sample_stored = res.sample_stored;
  assign error_flag = res.error_flag;
  assign ready_flag = res.ready_flag;
  assign query_code = res.query_code;

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    held && !advance |=> held)
    else $error("pending step dropped while output blocked");

  a_store_needs_read: assert property (@(posedge clk) disable iff (rst)
    result_valid && sample_stored |-> bus_action == BUS_PTR_READ)
    else $error("code stored without a conversion read");

  a_cfg_word_only_on_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && bus_action != BUS_WRITE_CFG |-> config_word == 16'd0)
    else $error("config word driven outside a config write");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(error_flag && ready_flag))
    else $error("error and ready flags both set");

  a_result_after_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("processed step produced no result");

endmodule

FILE: sim/tb_adc_channel_scan_sequencer.sv
module tb_adc_channel_scan_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import acss_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [31:0] tick;
    logic ok1;
    logic ok2;
    logic [15:0] word;
    logic [1:0] q;
  } poll_step_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic item_valid;
  logic item_ready;
  logic [31:0] now_tick;
  logic first_ok;
  logic second_ok;
  logic [15:0] read_word;
  logic [1:0] query_channel;
  logic result_valid;
  logic result_ready;
  logic [1:0] bus_action;
  logic [15:0] config_word;
  logic [1:0] active_channel;
  logic sample_stored;
  logic error_flag;
  logic ready_flag;
  logic [15:0] query_code;

  adc_channel_scan_sequencer dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .now_tick(now_tick),
    .first_ok(first_ok),
    .second_ok(second_ok),
    .read_word(read_word),
    .query_channel(query_channel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .bus_action(bus_action),
    .config_word(config_word),
    .active_channel(active_channel),
    .sample_stored(sample_stored),
    .error_flag(error_flag),
    .ready_flag(ready_flag),
    .query_code(query_code)
  );

  // scan state mirror
  phase_t scan_phase;
  logic [1:0] scan_ch;
  logic [31:0] conv_stamp;
  logic fault_q;
  logic done_q;
  logic [15:0] codes [CODE_DEPTH];
  logic [15:0] poll_cfg;
  logic [7:0] settle_cfg;

  result_t pending_results[$];
  result_t want;

  int n_fail;
  int cycle_count;
  bit idle_on;
  int hold_req;
  int ok_pct;
  logic [31:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int send_gap();
    if (!idle_on || $urandom_range(0, 99) < 65) return 0;
    return idle_len();
  endfunction

  initial begin
    int hold_cnt;
    int stall_cnt;
    hold_cnt = 0;
    stall_cnt = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        result_ready = 1'b0;
        hold_cnt--;
      end else if (!idle_on) begin
        result_ready = 1'b1;
      end else if (stall_cnt > 0) begin
        result_ready = 1'b0;
        stall_cnt--;
      end else if ($urandom_range(0, 99) < 20) begin
        result_ready = 1'b0;
        stall_cnt = idle_len() - 1;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending");
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        compare_field("bus_action", want.bus_action, bus_action);
        compare_field("config_word", want.config_word, config_word);
        compare_field("active_channel", want.active_channel, active_channel);
        compare_field("sample_stored", want.sample_stored, sample_stored);
        compare_field("error_flag", want.error_flag, error_flag);
        compare_field("ready_flag", want.ready_flag, ready_flag);
        compare_field("query_code", want.query_code, query_code);
      end
    end
  end

  task automatic clear_scan_state();
    scan_phase = PH_DETECT;
    scan_ch = '0;
    conv_stamp = '0;
    fault_q = 1'b0;
    done_q = 1'b0;
    foreach (codes[i]) codes[i] = '0;
    poll_cfg = POLL_RESET;
    settle_cfg = SETTLE_RESET;
  endtask

  task automatic advance_scan(input poll_step_t s);
    result_t r;
    logic [1:0] ch;
    logic [31:0] since;
    ch = scan_ch;
    since = s.tick - conv_stamp;
    r = '0;
    r.bus_action = BUS_NONE;
    r.active_channel = ch;
    case (scan_phase)
      PH_START: begin
        r.bus_action = BUS_WRITE_CFG;
        r.config_word = {CFG_HI_BASE | {2'b00, ch, 4'b0000}, CFG_LO};
        if (s.ok1) begin
          conv_stamp = s.tick;
          scan_phase = PH_READ;
        end else begin
          scan_phase = PH_ERROR;
        end
      end
      PH_READ: begin
        if (since >= {24'd0, settle_cfg}) begin
          r.bus_action = BUS_PTR_READ;
          if (s.ok1 && s.ok2) begin
            codes[ch] = s.word;
            r.sample_stored = 1'b1;
            if (ch != CH_LAST) begin
              scan_ch = ch + 2'd1;
              scan_phase = PH_START;
            end else begin
              done_q = 1'b1;
              scan_phase = PH_WAIT;
            end
          end else begin
            scan_phase = PH_ERROR;
          end
        end
      end
      PH_ERROR: begin
        fault_q = 1'b1;
        done_q = 1'b0;
        foreach (codes[i]) codes[i] = '0;
        conv_stamp = s.tick;
        scan_phase = PH_WAIT;
      end
      PH_WAIT: begin
        if (since >= {16'd0, poll_cfg}) scan_phase = PH_DETECT;
      end
      default: begin
        r.bus_action = BUS_DETECT;
        if (s.ok1) begin
          fault_q = 1'b0;
          scan_ch = '0;
          scan_phase = PH_START;
        end else begin
          scan_phase = PH_ERROR;
        end
      end
    endcase
    r.error_flag = fault_q;
    r.ready_flag = done_q;
    r.query_code = codes[s.q];
    pending_results.push_back(r);
  endtask

  task automatic send_step(input poll_step_t s);
    int gap;
    gap = send_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    now_tick = s.tick;
    first_ok = s.ok1;
    second_ok = s.ok2;
    read_word = s.word;
    query_channel = s.q;
    do @(posedge clk); while (!item_ready);
    advance_scan(s);
  endtask

  task automatic wait_results_in();
    @(negedge clk);
    item_valid = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    wait_results_in();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_POLL) poll_cfg = value[15:0];
    else settle_cfg = value[7:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] poll, input logic [7:0] settle);
    write_reg(REG_POLL, {16'd0, poll});
    write_reg(REG_SETTLE, {24'd0, settle});
  endtask

  function automatic poll_step_t make_step();
    poll_step_t s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) tick_now += $urandom_range(0, 4);
    else if (r < 80) tick_now += $urandom_range(0, settle_cfg + 4);
    else if (r < 95) tick_now += $urandom_range(0, poll_cfg + 4);
    else tick_now = $urandom;
    s.tick = tick_now;
    s.ok1 = $urandom_range(0, 99) < ok_pct;
    s.ok2 = $urandom_range(0, 99) < ok_pct;
    r = $urandom_range(0, 99);
    if (r < 10) s.word = 16'hFFFF;
    else if (r < 20) s.word = 16'h0000;
    else s.word = 16'($urandom);
    s.q = 2'($urandom);
    return s;
  endfunction

  task automatic send_directed(input int delta, input logic ok1, input logic ok2,
                               input logic [15:0] word);
    poll_step_t s;
    tick_now += delta;
    s.tick = tick_now;
    s.ok1 = ok1;
    s.ok2 = ok2;
    s.word = word;
    s.q = 2'($urandom);
    send_step(s);
  endtask

  task automatic test_directed_sequence();
    idle_on = 1'b1;
    tick_now = 32'hFFFF_FC00;
    send_directed(0, 1'b0, 1'b0, 16'h0000);
    send_directed(1, 1'b0, 1'b0, 16'h0000);
    send_directed(999, 1'b1, 1'b1, 16'h0000);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(3, 1'b1, 1'b0, 16'h0000);
    send_directed(2, 1'b1, 1'b0, 16'h0000);
    send_directed(19, 1'b1, 1'b1, 16'h1234);
    send_directed(1, 1'b1, 1'b1, 16'hFFFF);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(20, 1'b1, 1'b1, 16'h0000);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(25, 1'b1, 1'b1, 16'h8000);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(20, 1'b1, 1'b1, 16'h7FFF);
    send_directed(1000, 1'b1, 1'b1, 16'h0000);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(1, 1'b0, 1'b1, 16'h0000);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(1000, 1'b1, 1'b1, 16'h0000);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(20, 1'b0, 1'b1, 16'hAAAA);
    send_directed(1, 1'b1, 1'b1, 16'h0000);
    send_directed(1000, 1'b1, 1'b1, 16'h0000);
    send_directed(1, 1'b1, 1'b1, 16'h5555);
  endtask

  task automatic test_setting_extremes();
    logic [15:0] polls [4];
    logic [7:0] settles [4];
    polls = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
    settles = '{8'd0, 8'hFF, 8'hFF, 8'd0};
    idle_on = 1'b1;
    ok_pct = 96;
    for (int k = 0; k < 4; k++) begin
      set_timing(polls[k], settles[k]);
      repeat (40) send_step(make_step());
    end
  endtask

  task automatic test_random_scans();
    for (int k = 0; k < 5; k++) begin
      set_timing(16'($urandom_range(0, 300)), 8'($urandom_range(0, 40)));
      ok_pct = (k == 2) ? 60 : 96;
      idle_on = (k != 1);
      repeat (100) send_step(make_step());
    end
  endtask

  task automatic test_output_backpressure();
    set_timing(16'd30, 8'd5);
    idle_on = 1'b1;
    ok_pct = 96;
    hold_req = 300;
    @(negedge clk);
    repeat (60) begin
      tick_now += $urandom_range(0, 8);
      send_directed(0, $urandom_range(0, 99) < 96, 1'b1, 16'($urandom));
    end
    wait_results_in();
    repeat (30) send_step(make_step());
  endtask

  initial begin
    n_fail = 0;
    cycle_count = 0;
    idle_on = 1'b0;
    hold_req = 0;
    ok_pct = 96;
    tick_now = '0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    now_tick = '0;
    first_ok = 1'b0;
    second_ok = 1'b0;
    read_word = '0;
    query_channel = '0;
    clear_scan_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_sequence();
    test_setting_extremes();
    test_random_scans();
    test_output_backpressure();

    wait_results_in();
    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
